// File: rtl/mps_pkg.sv
`default_nettype none
package mps_pkg;
	localparam int unsigned NUM_ENTRIES = 32;
	localparam int unsigned MAX_PRIO = 10;
	localparam int unsigned IDX_W = $clog2(NUM_ENTRIES);
	localparam int unsigned SEL_W = IDX_W + 1;
	localparam logic [SEL_W-1:0] IDLE_SEL = SEL_W'(NUM_ENTRIES);

	typedef enum logic [1:0] {ST_FREE = 2'd0, ST_READY = 2'd1, ST_RUNNING = 2'd2,
		ST_DONE = 2'd3} status_t;

	localparam logic [1:0] CMD_CREATE = 2'd0;
	localparam logic [1:0] CMD_TIMER = 2'd1;
	localparam logic [1:0] CMD_RUN = 2'd2;
	// no-action code; also marks a pass that only refreshes the retired flag
	localparam logic [1:0] CMD_NONE = 2'd3;

	localparam logic [2:0] ALG_RR = 3'd0;
	localparam logic [2:0] ALG_PRIO = 3'd1;
	localparam logic [2:0] ALG_SRT = 3'd2;
	localparam logic [2:0] ALG_HOLD = 3'd3;
	localparam logic [2:0] ALG_LOT = 3'd4;
	localparam logic [2:0] ALG_HOLD_MAX = 3'd7;

	localparam logic [1:0] REG_ALGORITHM = 2'd0;
	localparam logic [1:0] REG_QUANTUM = 2'd1;
	localparam logic [1:0] REG_PREEMPTIVE = 2'd2;

	// per-cell view of one entry, walked through the ring
	typedef struct packed {
		status_t status;
		logic [3:0] prio;
		logic [15:0] remaining;
		logic [6:0] tickets;
	} entry_t;

	// control from the sequencer to every cell
	typedef struct packed {
		logic shift;                 // rotate the ring by one cell
		logic write_head;            // replace head entry
		entry_t head_new;
	} cell_ctl_t;

	function automatic logic [6:0] ticket_of(input logic [3:0] p);
		logic [6:0] t;
		case (p)
			4'd0: t = 7'd100;
			4'd1: t = 7'd50;
			4'd2: t = 7'd33;
			4'd3: t = 7'd25;
			4'd4: t = 7'd20;
			4'd5: t = 7'd16;
			4'd6: t = 7'd14;
			4'd7: t = 7'd12;
			4'd8: t = 7'd11;
			4'd9: t = 7'd10;
			4'd10: t = 7'd9;
			4'd11: t = 7'd8;
			4'd12: t = 7'd7;
			4'd13: t = 7'd7;
			4'd14: t = 7'd6;
			default: t = 7'd6;
		endcase
		return t;
	endfunction
endpackage
`default_nettype wire

// File: rtl/mps_cell.sv
`default_nettype none
module mps_cell import mps_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire cell_ctl_t ctl,
	input wire entry_t from_prev,
	input wire logic is_tail,
	output entry_t entry
);
	status_t status_q;
	logic [3:0] prio_q;
	logic [15:0] remaining_q;
	logic [6:0] tickets_q;

	// the tail takes the head entry as the ring turns, rewritten when asked
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q <= ST_FREE;
		end else if (ctl.shift) begin
			status_q <= (ctl.write_head && is_tail) ? ctl.head_new.status :
				from_prev.status;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			if (ctl.write_head && is_tail) begin
				prio_q <= ctl.head_new.prio;
				remaining_q <= ctl.head_new.remaining;
				tickets_q <= ctl.head_new.tickets;
			end else begin
				prio_q <= from_prev.prio;
				remaining_q <= from_prev.remaining;
				tickets_q <= from_prev.tickets;
			end
		end
	end

	assign entry = '{status: status_q, prio: prio_q, remaining: remaining_q,
		tickets: tickets_q};
endmodule
`default_nettype wire

// File: rtl/mps_divmod.sv
`default_nettype none
module mps_divmod import mps_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic go,
	input wire logic [15:0] dividend,
	input wire logic [11:0] divisor,
	output logic done,
	output logic [11:0] remainder
);
	logic [15:0] num_q;
	logic [12:0] rem_q;
	logic [4:0] cnt_q;
	logic busy_q;
	logic [12:0] trial;

	assign trial = {rem_q[11:0], num_q[15]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q <= 5'd16;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			num_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[14:0], 1'b0};
			rem_q <= (trial >= {1'b0, divisor}) ? trial - {1'b0, divisor} : trial;
		end
	end

	assign remainder = rem_q[11:0];
endmodule
`default_nettype wire

// File: rtl/multi_policy_process_scheduler.sv
`default_nettype none
// Multi-policy process scheduler.
// Command beats (command, burst_len, priority_req, random_value) are taken
// at a clock edge with start high and busy low; busy rises the cycle after
// and stays high until the result beat. done is then high for one cycle
// with created_index, table_full, selected, switched, finished, all_retired
// and context_switches; the receiver cannot stall, the beat is taken there.
// cfg_we/cfg_index/cfg_data write algorithm, quantum, preemptive at the edge;
// the user must write them only while no command is in flight; not enforced.
// The table sits in a ring of 32 cells turned one cell a cycle during a pass,
// so each pass shows every entry at the head and ends with the ring home.
// Sequence, accept edge to result edge: create takes an insert pass and a
// retired pass; timer/run take a retired pass, a select pass, a settle step,
// an update pass and a retired pass; lottery swaps the select pass for a
// ticket sum pass, a remainder division and a draw pass, or the sum pass alone
// when no tickets are live; run with all retired, timer without preemption and
// the no-action code take the retired pass only. No new command until busy falls.
// Reset: all entries free, running idle (32), switch count zero,
// algorithm 0, quantum 100, preemptive 1.
module multi_policy_process_scheduler import mps_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire logic cfg_we,
	input wire logic [1:0] cfg_index,
	input wire logic [15:0] cfg_data,
	input wire logic [1:0] command,
	input wire logic [15:0] burst_len,
	input wire logic [3:0] priority_req,
	input wire logic [15:0] random_value,
	output logic done,
	output logic [4:0] created_index,
	output logic table_full,
	output logic [5:0] selected,
	output logic switched,
	output logic finished,
	output logic all_retired,
	output logic [15:0] context_switches
);
	typedef enum logic [3:0] {S_IDLE, S_CREATE, S_CHECK, S_SEL, S_SUM, S_DIV,
		S_DRAW, S_UPDATE, S_RESULT} state_t;

	state_t state_q;
	logic [2:0] alg_q;
	logic [15:0] quantum_q;
	logic pre_q;

	logic [1:0] cmd_q;
	logic [15:0] burst_q;
	logic [3:0] prio_q;
	logic [15:0] draw_q;

	logic [SEL_W-1:0] count_q, run_q, win_q, pos_q;
	logic [SEL_W-1:0] rr_start;
	logic [15:0] sw_total_q;
	logic [16:0] best_q;
	logic [11:0] total_q, acc_q;
	logic found_q, alldone_q, notdone_q, sw_q, fin_q, full_q;
	logic [4:0] created_q;
	logic wr_phase_q;
	logic div_go;
	logic div_done;
	logic [11:0] target;

	cell_ctl_t ctl;
	entry_t cells [NUM_ENTRIES];
	entry_t head;
	entry_t created_e;
	entry_t upd;
	logic upd_fin;

	logic in_use, cand, not_retired;
	logic [SEL_W-1:0] next_sel;
	logic last_pos;
	logic [3:0] sat_prio;
	logic [SEL_W-1:0] rr_rel, best_rel;

	genvar g;
	generate
		for (g = 0; g < NUM_ENTRIES; g++) begin : g_cell
			mps_cell u_cell (
				.clk(clk), .arst_n(arst_n), .ctl(ctl),
				.from_prev(cells[(g + 1) % NUM_ENTRIES]),
				.is_tail(g == NUM_ENTRIES - 1), .entry(cells[g]));
		end
	endgenerate
	assign head = cells[0];

	mps_divmod u_div (.clk(clk), .arst_n(arst_n), .go(div_go),
		.dividend(draw_q), .divisor(total_q), .done(div_done), .remainder(target));

	assign in_use = pos_q < count_q;
	assign cand = in_use && (head.status == ST_READY || head.status == ST_RUNNING);
	// some admitted entry seen so far in this pass is not retired
	assign not_retired = notdone_q || (in_use && head.status != ST_DONE);
	assign last_pos = pos_q == SEL_W'(NUM_ENTRIES - 1);
	assign sat_prio = (priority_req > 4'(MAX_PRIO)) ? 4'(MAX_PRIO) : priority_req;
	assign rr_start = (run_q < count_q) ?
		((run_q + 1'b1 == count_q) ? '0 : run_q + 1'b1) : '0;
	assign next_sel = found_q ? win_q : IDLE_SEL;
	assign busy = state_q != S_IDLE;

	// rotation distance of round robin: position relative to rr_start
	assign rr_rel = (pos_q >= rr_start) ? pos_q - rr_start : pos_q + count_q - rr_start;
	assign best_rel = (win_q >= rr_start) ? win_q - rr_start : win_q + count_q - rr_start;

	// created entry goes into the ring as the pass passes position count
	assign created_e = '{status: ST_READY, prio: prio_q, remaining: burst_q,
		tickets: ticket_of(prio_q)};

	// update pass: rewrite the head entry on the way round
	always_comb begin
		upd = head;
		upd_fin = 1'b0;
		if (in_use && sw_q && pos_q == run_q && head.status == ST_RUNNING)
			upd.status = ST_READY;
		if (in_use && pos_q == next_sel) begin
			if (sw_q)
				upd.status = ST_RUNNING;
			if (cmd_q == CMD_RUN && upd.status == ST_RUNNING) begin
				if (head.remaining <= quantum_q) begin
					upd.remaining = '0;
					upd.status = ST_DONE;
					upd_fin = 1'b1;
				end else begin
					upd.remaining = head.remaining - quantum_q;
				end
			end
		end
		ctl.shift = 1'b0;
		ctl.write_head = 1'b0;
		ctl.head_new = upd;
		case (state_q)
			S_CHECK, S_SEL, S_SUM, S_DRAW: ctl.shift = 1'b1;
			S_UPDATE: begin
				// the settle cycle holds the ring still
				ctl.shift = wr_phase_q;
				ctl.write_head = wr_phase_q;
			end
			S_CREATE: begin
				ctl.shift = 1'b1;
				if (pos_q == count_q && !full_q) begin
					ctl.write_head = 1'b1;
					ctl.head_new = created_e;
				end
			end
			default: ctl.shift = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			alg_q <= ALG_RR;
			quantum_q <= 16'd100;
			pre_q <= 1'b1;
			count_q <= '0;
			run_q <= IDLE_SEL;
			sw_total_q <= '0;
			done <= 1'b0;
			div_go <= 1'b0;
			wr_phase_q <= 1'b0;
			cmd_q <= CMD_NONE;
			burst_q <= '0;
			prio_q <= '0;
			draw_q <= '0;
			pos_q <= '0;
			win_q <= IDLE_SEL;
			best_q <= '0;
			total_q <= '0;
			acc_q <= '0;
			found_q <= 1'b0;
			alldone_q <= 1'b1;
			notdone_q <= 1'b0;
			sw_q <= 1'b0;
			fin_q <= 1'b0;
			full_q <= 1'b0;
			created_q <= '0;
		end else begin
			done <= state_q == S_RESULT;
			div_go <= state_q == S_SUM && last_pos;
			if (cfg_we) begin
				case (cfg_index)
					REG_ALGORITHM: alg_q <= cfg_data[2:0];
					REG_QUANTUM: quantum_q <= cfg_data;
					REG_PREEMPTIVE: pre_q <= cfg_data[0];
					default: ;
				endcase
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						// commands with no action still take the retired pass
						cmd_q <= (command == CMD_CREATE || command == CMD_RUN ||
							(command == CMD_TIMER && pre_q)) ? command : CMD_NONE;
						burst_q <= burst_len;
						prio_q <= sat_prio;
						draw_q <= random_value;
						pos_q <= '0;
						sw_q <= 1'b0;
						fin_q <= 1'b0;
						full_q <= command == CMD_CREATE && count_q >= SEL_W'(NUM_ENTRIES);
						created_q <= '0;
						alldone_q <= 1'b1;
						notdone_q <= 1'b0;
						state_q <= (command == CMD_CREATE) ? S_CREATE : S_CHECK;
					end
				end
				S_CREATE: begin
					pos_q <= last_pos ? '0 : pos_q + 1'b1;
					if (last_pos) begin
						if (!full_q) begin
							created_q <= count_q[4:0];
							count_q <= count_q + 1'b1;
						end
						state_q <= S_CHECK;
						cmd_q <= CMD_NONE;
					end
				end
				S_CHECK: begin
					// retired pass; also starts selection bookkeeping
					pos_q <= last_pos ? '0 : pos_q + 1'b1;
					if (last_pos) begin
						notdone_q <= 1'b0;
						found_q <= 1'b0;
						best_q <= (alg_q == ALG_PRIO) ? 17'(MAX_PRIO + 1) : 17'h10000;
						total_q <= '0;
						acc_q <= '0;
						if (cmd_q == CMD_NONE || (cmd_q == CMD_RUN && !not_retired)) begin
							alldone_q <= !not_retired;
							state_q <= S_RESULT;
						end else if (alg_q == ALG_LOT) begin
							state_q <= S_SUM;
						end else begin
							state_q <= S_SEL;
						end
					end else if (not_retired) begin
						notdone_q <= 1'b1;
					end
				end
				S_SEL: begin
					pos_q <= last_pos ? '0 : pos_q + 1'b1;
					case (alg_q)
						ALG_RR: begin
							if (cand && (!found_q || rr_rel < best_rel)) begin
								found_q <= 1'b1;
								win_q <= pos_q;
							end
						end
						ALG_PRIO: begin
							if (cand && 17'(head.prio) < best_q) begin
								best_q <= 17'(head.prio);
								found_q <= 1'b1;
								win_q <= pos_q;
							end
						end
						ALG_SRT: begin
							if (cand && 17'(head.remaining) < best_q) begin
								best_q <= 17'(head.remaining);
								found_q <= 1'b1;
								win_q <= pos_q;
							end
						end
						default: begin
							found_q <= run_q != IDLE_SEL;
							win_q <= run_q;
						end
					endcase
					if (last_pos)
						state_q <= S_UPDATE;
				end
				S_SUM: begin
					pos_q <= last_pos ? '0 : pos_q + 1'b1;
					if (cand)
						total_q <= total_q + 12'(head.tickets);
					if (last_pos)
						state_q <= S_DIV;
				end
				S_DIV: begin
					if (total_q == '0) begin
						state_q <= S_UPDATE;
					end else if (div_done) begin
						state_q <= S_DRAW;
					end
				end
				S_DRAW: begin
					pos_q <= last_pos ? '0 : pos_q + 1'b1;
					if (cand && !found_q) begin
						acc_q <= acc_q + 12'(head.tickets);
						if (acc_q + 12'(head.tickets) > target) begin
							found_q <= 1'b1;
							win_q <= pos_q;
						end
					end
					if (last_pos)
						state_q <= S_UPDATE;
				end
				S_UPDATE: begin
					// a settle step first sets the switch flag, then one pass rewrites
					if (!wr_phase_q) begin
						wr_phase_q <= 1'b1;
						sw_q <= next_sel != run_q;
					end else begin
						pos_q <= last_pos ? '0 : pos_q + 1'b1;
						if (upd_fin)
							fin_q <= 1'b1;
						if (last_pos) begin
							wr_phase_q <= 1'b0;
							if (sw_q) begin
								run_q <= next_sel;
								if (next_sel != IDLE_SEL && sw_total_q != 16'hFFFF)
									sw_total_q <= sw_total_q + 1'b1;
							end
							cmd_q <= CMD_NONE;
							state_q <= S_CHECK;
						end
					end
				end
				S_RESULT: begin
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign created_index = created_q;
	assign table_full = full_q;
	assign selected = run_q;
	assign switched = sw_q;
	assign finished = fin_q;
	assign all_retired = alldone_q;
	assign context_switches = sw_total_q;
endmodule
`default_nettype wire
